// File: hdl/pcvh_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcvh_pkg: shared types and constants of the voxel histogram
// Command and result codes, field widths, the controller/datapath command and
// status records, and the count saturation helper.
// ---------------------------------------------------------------------------
package pcvh_pkg;

  localparam int GRID_CELLS_DEF = 16;
  localparam int MAX_POINTS_DEF = 4096;

  localparam int COORD_W    = 16;
  localparam int CELL_IDX_W = 4;
  localparam int MARGIN_W   = 10;
  localparam int CNT_OUT_W  = 13;

  localparam logic [MARGIN_W-1:0]  MARGIN_RESET = 10'd10;
  localparam logic [CNT_OUT_W-1:0] CNT_SAT      = 13'h1FFF;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_READ     = 1'b1;
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_CELL    = 1'b1;

  typedef struct packed {
    logic load_pt;
    logic rd_cell;
    logic setup_s;
    logic setup_b;
    logic clr_wr;
    logic pt_rd;
    logic pt_ld;
    logic chk;
    logic div_step;
    logic cnt_rd;
    logic cnt_wr;
    logic pt_next;
    logic out_sum;
    logic out_cell;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic no_pts;
    logic pt_last;
    logic hit;
    logic div_last;
  } dp_status_t;

  function automatic logic [CNT_OUT_W-1:0] sat_cnt(input logic [31:0] v);
    return (v > 32'(CNT_SAT)) ? CNT_SAT : v[CNT_OUT_W-1:0];
  endfunction

endpackage

// File: hdl/pcvh_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcvh_ctrl: sequencer of the voxel histogram
// Accepts beats, steps the datapath through setup, count clearing and the
// per-point binning loop, and owns the output valid flag.
// ---------------------------------------------------------------------------
module pcvh_ctrl import pcvh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic       last_point,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t sts
);

  localparam logic [3:0] ST_INIT    = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_SETUP_S = 4'd2;
  localparam logic [3:0] ST_SETUP_B = 4'd3;
  localparam logic [3:0] ST_CLR     = 4'd4;
  localparam logic [3:0] ST_P_RD    = 4'd5;
  localparam logic [3:0] ST_P_LD    = 4'd6;
  localparam logic [3:0] ST_CHK     = 4'd7;
  localparam logic [3:0] ST_DIV     = 4'd8;
  localparam logic [3:0] ST_C_RD    = 4'd9;
  localparam logic [3:0] ST_C_WR    = 4'd10;
  localparam logic [3:0] ST_SUM     = 4'd11;
  localparam logic [3:0] ST_RD_WAIT = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_READ) begin
            cmd.rd_cell = 1'b1;
            state_next  = ST_RD_WAIT;
          end else begin
            cmd.load_pt = 1'b1;
            if (last_point) begin
              state_next = ST_SETUP_S;
            end
          end
        end
      end
      ST_SETUP_S: begin
        cmd.setup_s = 1'b1;
        state_next  = ST_SETUP_B;
      end
      ST_SETUP_B: begin
        cmd.setup_b = 1'b1;
        state_next  = ST_CLR;
      end
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = sts.no_pts ? ST_SUM : ST_P_RD;
        end
      end
      ST_P_RD: begin
        cmd.pt_rd  = 1'b1;
        state_next = ST_P_LD;
      end
      ST_P_LD: begin
        cmd.pt_ld  = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          if (sts.hit) begin
            state_next = ST_C_RD;
          end else if (sts.pt_last) begin
            state_next = ST_SUM;
          end else begin
            cmd.pt_next = 1'b1;
            state_next  = ST_P_RD;
          end
        end
      end
      ST_C_RD: begin
        cmd.cnt_rd = 1'b1;
        state_next = ST_C_WR;
      end
      ST_C_WR: begin
        cmd.cnt_wr = 1'b1;
        if (sts.pt_last) begin
          state_next = ST_SUM;
        end else begin
          cmd.pt_next = 1'b1;
          state_next  = ST_P_RD;
        end
      end
      ST_SUM: begin
        if (slot_free) begin
          cmd.out_sum = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_RD_WAIT: begin
        if (slot_free) begin
          cmd.out_cell = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_sum || cmd.out_cell) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A result is only written into the output register once it is free.
  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_sum || cmd.out_cell) |-> slot_free)
    else $error("result loaded over a waiting beat");

  // The last point starts binning, so no further beat is taken right after it.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_LOAD && last_point) |=> !in_ready)
    else $error("input taken during binning");

  // Every count increment is preceded by the read of that count.
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_wr |-> $past(cmd.cnt_rd))
    else $error("count written without a prior read");

endmodule

// File: hdl/pcvh_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcvh_datapath: storage and arithmetic of the voxel histogram
// Point store, voxel count store, bounding box, grid setup, a bit-serial
// cell search per axis, summary counters and the output register.
// ---------------------------------------------------------------------------
module pcvh_datapath import pcvh_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dp_cmd_t                     cmd,
  output dp_status_t                  sts,
  input  logic signed [COORD_W-1:0]   point_x,
  input  logic signed [COORD_W-1:0]   point_y,
  input  logic signed [COORD_W-1:0]   point_z,
  input  logic [CELL_IDX_W-1:0]       cell_x,
  input  logic [CELL_IDX_W-1:0]       cell_y,
  input  logic [CELL_IDX_W-1:0]       cell_z,
  input  logic                        cfg_wr_en,
  input  logic [MARGIN_W-1:0]         cfg_wr_data,
  output logic                        result_kind,
  output logic [CNT_OUT_W-1:0]        cell_count,
  output logic [CNT_OUT_W-1:0]        binned_total,
  output logic [CNT_OUT_W-1:0]        peak_count,
  output logic                        points_dropped
);

  localparam int CW  = $clog2(GRID_CELLS);
  localparam int NC  = GRID_CELLS * GRID_CELLS * GRID_CELLS;
  localparam int NCW = $clog2(NC);
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int LW  = $clog2(MAX_POINTS + 1);
  localparam int GB  = $clog2(GRID_CELLS + 1);
  localparam int EW  = 21 + GB;

  localparam logic signed [EW-1:0] G_S      = EW'(GRID_CELLS);
  localparam logic signed [EW-1:0] G2_S     = EW'(2 * GRID_CELLS);
  localparam logic [CW-1:0]        CELL_MAX = CW'(GRID_CELLS - 1);
  localparam logic [CW-1:0]        MASK_TOP = CW'(1 << (CW - 1));
  localparam logic [NCW-1:0]       ROW      = NCW'(GRID_CELLS);
  localparam logic [NCW-1:0]       PLANE    = NCW'(GRID_CELLS * GRID_CELLS);
  localparam logic [NCW-1:0]       CLR_END  = NCW'(NC - 1);
  localparam logic [LW-1:0]        CAP      = LW'(MAX_POINTS);

  // Configuration and object state.
  logic [MARGIN_W-1:0]       margin;
  logic signed [COORD_W-1:0] axis_min [3];
  logic signed [COORD_W-1:0] axis_max [3];
  logic signed [COORD_W-1:0] pin [3];
  logic [LW-1:0]             loaded;
  logic                      ovf;
  logic                      room;

  // Stores.
  logic [3*COORD_W-1:0] pt_mem [MAX_POINTS];
  logic [3*COORD_W-1:0] pt_q;
  logic [LW-1:0]        cnt_mem [NC];
  logic [LW-1:0]        cnt_q;
  logic [LW-1:0]        cnt_inc;
  logic [NCW-1:0]       clr_addr;
  logic [NCW-1:0]       bin_addr;
  logic [NCW-1:0]       cell_addr;
  logic [NCW-1:0]       rd_addr;
  logic [NCW-1:0]       wr_addr;
  logic [LW-1:0]        wr_data;
  logic                 cell_in_grid;
  logic                 cell_ok;

  // Grid setup and cell search.
  logic signed [COORD_W:0] side [3];
  logic signed [COORD_W:0] s_next;
  logic [COORD_W-1:0]      s;
  logic signed [EW-1:0]    s_e;
  logic signed [EW-1:0]    w_e;
  logic signed [EW-1:0]    sum_e [3];
  logic signed [EW-1:0]    p_e [3];
  logic signed [EW-1:0]    base [3];
  logic signed [EW-1:0]    hi;
  logic signed [EW-1:0]    wlim;
  logic signed [EW-1:0]    div0;
  logic signed [EW-1:0]    div;
  logic signed [EW-1:0]    r [3];
  logic [CW-1:0]           c [3];
  logic [CW-1:0]           mask;
  logic                    hit;
  logic [PW-1:0]           k;

  // Summary.
  logic [LW-1:0] tot;
  logic [LW-1:0] peak;

  assign pin[0] = point_x;
  assign pin[1] = point_y;
  assign pin[2] = point_z;
  assign room   = (loaded < CAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= MARGIN_RESET;
    end else if (cfg_wr_en) begin
      margin <= cfg_wr_data;
    end
  end

  // Bounding box and fill count; a summary returns the object to empty.
  always_ff @(posedge clk) begin
    if (rst || cmd.out_sum) begin
      for (int a = 0; a < 3; a++) begin
        axis_min[a] <= 16'sh7FFF;
        axis_max[a] <= 16'sh8000;
      end
      loaded <= '0;
      ovf    <= 1'b0;
    end else if (cmd.load_pt) begin
      if (room) begin
        for (int a = 0; a < 3; a++) begin
          if (pin[a] < axis_min[a]) begin
            axis_min[a] <= pin[a];
          end
          if (pin[a] > axis_max[a]) begin
            axis_max[a] <= pin[a];
          end
        end
        loaded <= loaded + LW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pt && room) begin
      pt_mem[loaded[PW-1:0]] <= {point_x, point_y, point_z};
    end
    if (cmd.pt_rd) begin
      pt_q <= pt_mem[k];
    end
  end

  // Largest side of the box becomes the cube edge.
  always_comb begin
    s_next = '0;
    for (int a = 0; a < 3; a++) begin
      side[a] = {axis_max[a][COORD_W-1], axis_max[a]} - {axis_min[a][COORD_W-1], axis_min[a]};
      sum_e[a] = EW'(signed'({axis_max[a][COORD_W-1], axis_max[a]}
                             + {axis_min[a][COORD_W-1], axis_min[a]}));
      if (side[a] > s_next) begin
        s_next = side[a];
      end
    end
  end

  assign s_e = EW'(s);
  assign w_e = G2_S * signed'(EW'(margin));

  assign p_e[0] = EW'(signed'(pt_q[3*COORD_W-1:2*COORD_W]));
  assign p_e[1] = EW'(signed'(pt_q[2*COORD_W-1:COORD_W]));
  assign p_e[2] = EW'(signed'(pt_q[COORD_W-1:0]));

  // Edges are kept relative to the inner edge origin base, in units of
  // 1/(2G) mm; the cell index is the quotient (2Gp - base) / 2S, capped at
  // G-1, found one bit per step by restoring division on all three axes.
  always_ff @(posedge clk) begin
    if (cmd.setup_s) begin
      s <= s_next[COORD_W-1:0];
    end
    if (cmd.setup_b) begin
      for (int a = 0; a < 3; a++) begin
        base[a] <= G_S * sum_e[a] - G_S * s_e;
      end
      hi   <= G2_S * s_e + w_e;
      wlim <= w_e;
      div0 <= s_e <<< CW;
    end
    if (cmd.pt_ld) begin
      for (int a = 0; a < 3; a++) begin
        r[a] <= G2_S * p_e[a] - base[a];
      end
    end
    if (cmd.chk) begin
      hit <= (r[0] + wlim >= 0) && (r[0] < hi)
          && (r[1] + wlim >= 0) && (r[1] < hi)
          && (r[2] + wlim >= 0) && (r[2] < hi);
      for (int a = 0; a < 3; a++) begin
        c[a] <= '0;
      end
      mask <= MASK_TOP;
      div  <= div0;
    end
    if (cmd.div_step) begin
      for (int a = 0; a < 3; a++) begin
        if (((c[a] | mask) <= CELL_MAX) && (r[a] >= div)) begin
          r[a] <= r[a] - div;
          c[a] <= c[a] | mask;
        end
      end
      div  <= div >>> 1;
      mask <= mask >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.setup_s) begin
      k <= '0;
    end else if (cmd.pt_next) begin
      k <= k + PW'(1);
    end
  end

  // Voxel count store: one write port shared by clearing and increments,
  // one read port shared by binning and read commands.
  assign bin_addr     = NCW'(c[0]) * PLANE + NCW'(c[1]) * ROW + NCW'(c[2]);
  assign cell_addr    = NCW'(cell_x) * PLANE + NCW'(cell_y) * ROW + NCW'(cell_z);
  assign cell_in_grid = (32'(cell_x) < GRID_CELLS) && (32'(cell_y) < GRID_CELLS)
                     && (32'(cell_z) < GRID_CELLS);
  assign rd_addr      = cmd.cnt_rd ? bin_addr : cell_addr;
  assign wr_addr      = cmd.clr_wr ? clr_addr : bin_addr;
  assign cnt_inc      = cnt_q + LW'(1);
  assign wr_data      = cmd.clr_wr ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.cnt_wr) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (cmd.cnt_rd || cmd.rd_cell) begin
      cnt_q <= cnt_mem[rd_addr];
    end
    if (cmd.rd_cell) begin
      cell_ok <= cell_in_grid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.setup_s) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + NCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.setup_s) begin
      tot  <= '0;
      peak <= '0;
    end else if (cmd.cnt_wr) begin
      tot <= tot + LW'(1);
      if (cnt_inc > peak) begin
        peak <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_sum || cmd.out_cell) begin
      result_kind    <= cmd.out_cell ? KIND_CELL : KIND_SUMMARY;
      cell_count     <= (cmd.out_cell && cell_ok) ? sat_cnt(32'(cnt_q)) : '0;
      binned_total   <= sat_cnt(32'(tot));
      peak_count     <= sat_cnt(32'(peak));
      points_dropped <= ovf;
    end
  end

  assign sts.clr_last = (clr_addr == CLR_END);
  assign sts.no_pts   = (loaded == '0);
  assign sts.pt_last  = (LW'(k) + LW'(1) == loaded);
  assign sts.hit      = hit;
  assign sts.div_last = mask[0];

endmodule

// File: hdl/point_cloud_voxel_histogram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_cloud_voxel_histogram: voxel grid histogram of one point-cloud object
// Loads points, bins them into a GRID_CELLS^3 count grid centered on the
// bounding box after the last point, and answers cell count reads.
// ---------------------------------------------------------------------------
//  Channel | Handshake              | Beat contents
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_ready    | command, point_x/y/z, last_point, cell_x/y/z
//  out     | out_valid / out_ready  | result_kind, cell_count, binned_total,
//          |                        | peak_count, points_dropped
//  cfg     | cfg_wr_en              | cfg_wr_data (edge margin, mm)
//
// Point loads are taken back to back and keep flowing while a result waits.
// A read fetches the addressed count; the last point starts grid setup, a
// clearing pass over all GRID_CELLS^3 count cells, then for each stored point
// a read, a range check and the cell search, plus a count increment for each
// point inside the grid, and finally the summary.
// The per-point time is set by the one-bit-per-cycle cell search and the
// read-modify-write on the single count store.
// After reset a clearing pass over all GRID_CELLS^3 cells runs, in_ready low.
// Reads and last points hold in the block until the output register is free.
// ---------------------------------------------------------------------------
module point_cloud_voxel_histogram import pcvh_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      command,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic                      last_point,
  input  logic [CELL_IDX_W-1:0]     cell_x,
  input  logic [CELL_IDX_W-1:0]     cell_y,
  input  logic [CELL_IDX_W-1:0]     cell_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      result_kind,
  output logic [CNT_OUT_W-1:0]      cell_count,
  output logic [CNT_OUT_W-1:0]      binned_total,
  output logic [CNT_OUT_W-1:0]      peak_count,
  output logic                      points_dropped,
  input  logic                      cfg_wr_en,
  input  logic [MARGIN_W-1:0]       cfg_wr_data
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  pcvh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .last_point (last_point),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  pcvh_datapath #(
    .GRID_CELLS (GRID_CELLS),
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .cell_x         (cell_x),
    .cell_y         (cell_y),
    .cell_z         (cell_z),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .result_kind    (result_kind),
    .cell_count     (cell_count),
    .binned_total   (binned_total),
    .peak_count     (peak_count),
    .points_dropped (points_dropped)
  );

endmodule

// File: tb/tb_point_cloud_voxel_histogram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_point_cloud_voxel_histogram: self-checking bench for the voxel histogram
// Drives point loads, last points and cell reads through the valid/ready
// input, predicts every summary and cell reply in a scoreboard, and checks
// each output beat field by field under random idling on both channels.
// ---------------------------------------------------------------------------
module tb_point_cloud_voxel_histogram;
  import pcvh_pkg::*;

  localparam int GRID         = GRID_CELLS_DEF;
  localparam int MAX_PTS      = MAX_POINTS_DEF;
  localparam int NUM_CELLS    = GRID * GRID * GRID;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 20_000_000;

  typedef struct packed {
    logic                  command;
    logic [COORD_W-1:0]    px;
    logic [COORD_W-1:0]    py;
    logic [COORD_W-1:0]    pz;
    logic                  last;
    logic [CELL_IDX_W-1:0] cx;
    logic [CELL_IDX_W-1:0] cy;
    logic [CELL_IDX_W-1:0] cz;
  } voxel_req_t;

  typedef struct packed {
    logic                 kind;
    logic [CNT_OUT_W-1:0] cnt;
    logic [CNT_OUT_W-1:0] total;
    logic [CNT_OUT_W-1:0] peak;
    logic                 dropped;
  } voxel_reply_t;

  // Tracks the object being loaded and the last histogram, and queues the
  // reply each accepted beat is due to produce.
  class voxel_histogram_board;
    shortint      pt_mem[MAX_PTS][3];
    int           counts[NUM_CELLS];
    int           lo[3];
    int           hi[3];
    int           n_loaded;
    bit           dropped;
    int           total;
    int           peak;
    int           margin;
    int           errors;
    voxel_reply_t due[$];
    int           filled_cells[$];

    function new();
      foreach (counts[i]) counts[i] = 0;
      total  = 0;
      peak   = 0;
      margin = int'(MARGIN_RESET);
      errors = 0;
      clear_object();
    endfunction

    function void clear_object();
      for (int a = 0; a < 3; a++) begin
        lo[a] = 32767;
        hi[a] = -32768;
      end
      n_loaded = 0;
      dropped  = 1'b0;
    endfunction

    function void set_margin(int m);
      margin = m;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function logic [CNT_OUT_W-1:0] clip_count(int v);
      return (v > 8191) ? 13'd8191 : CNT_OUT_W'(v);
    endfunction

    // Cube of edge s centered on the box; the outer edges move out by the
    // margin. All edges are in units of 1/(2*GRID) mm, so nothing rounds.
    function void bin_points();
      longint edges[3][GRID+1];
      longint s;
      longint side;
      longint base;
      longint widen;
      longint p;
      int     c[3];
      int     idx;
      bit     in_grid;
      s     = 0;
      widen = 2 * GRID * longint'(margin);
      for (int a = 0; a < 3; a++) begin
        side = longint'(hi[a]) - longint'(lo[a]);
        if (side > s) s = side;
      end
      for (int a = 0; a < 3; a++) begin
        base = GRID * (longint'(lo[a]) + longint'(hi[a])) - GRID * s;
        for (int i = 0; i <= GRID; i++) edges[a][i] = base + 2 * s * i;
        edges[a][0]    -= widen;
        edges[a][GRID] += widen;
      end
      foreach (counts[i]) counts[i] = 0;
      filled_cells.delete();
      total = 0;
      peak  = 0;
      for (int k = 0; k < n_loaded; k++) begin
        in_grid = 1'b1;
        for (int a = 0; a < 3; a++) begin
          p    = 2 * GRID * longint'(pt_mem[k][a]);
          c[a] = -1;
          for (int i = 0; i < GRID; i++) begin
            if (edges[a][i] <= p && p < edges[a][i+1]) begin
              c[a] = i;
              break;
            end
          end
          if (c[a] < 0) in_grid = 1'b0;
        end
        if (in_grid) begin
          idx = (c[0] * GRID + c[1]) * GRID + c[2];
          if (counts[idx] == 0) filled_cells = {filled_cells, idx};
          counts[idx]++;
          total++;
          if (counts[idx] > peak) peak = counts[idx];
        end
      end
    endfunction

    function void note_beat(voxel_req_t b);
      voxel_reply_t r;
      int           v[3];
      if (b.command == CMD_READ) begin
        r.kind    = KIND_CELL;
        r.cnt     = clip_count(counts[(int'(b.cx) * GRID + int'(b.cy)) * GRID + int'(b.cz)]);
        r.total   = clip_count(total);
        r.peak    = clip_count(peak);
        r.dropped = dropped;
        due       = {due, r};
        return;
      end
      if (n_loaded < MAX_PTS) begin
        v[0] = int'(shortint'(b.px));
        v[1] = int'(shortint'(b.py));
        v[2] = int'(shortint'(b.pz));
        for (int a = 0; a < 3; a++) begin
          pt_mem[n_loaded][a] = shortint'(v[a]);
          if (v[a] < lo[a]) lo[a] = v[a];
          if (v[a] > hi[a]) hi[a] = v[a];
        end
        n_loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (!b.last) return;
      bin_points();
      r.kind    = KIND_SUMMARY;
      r.cnt     = '0;
      r.total   = clip_count(total);
      r.peak    = clip_count(peak);
      r.dropped = dropped;
      due       = {due, r};
      clear_object();
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(voxel_reply_t r);
      voxel_reply_t want;
      if (due.size() == 0) begin
        $error("result beat with nothing outstanding: kind %0d total %0d", r.kind, r.total);
        errors++;
        return;
      end
      want = due.pop_front();
      compare_field("result_kind", want.kind, r.kind);
      compare_field("cell_count", want.cnt, r.cnt);
      compare_field("binned_total", want.total, r.total);
      compare_field("peak_count", want.peak, r.peak);
      compare_field("points_dropped", want.dropped, r.dropped);
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      command;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic                      last_point;
  logic [CELL_IDX_W-1:0]     cell_x;
  logic [CELL_IDX_W-1:0]     cell_y;
  logic [CELL_IDX_W-1:0]     cell_z;
  logic                      out_valid;
  logic                      out_ready;
  logic                      result_kind;
  logic [CNT_OUT_W-1:0]      cell_count;
  logic [CNT_OUT_W-1:0]      binned_total;
  logic [CNT_OUT_W-1:0]      peak_count;
  logic                      points_dropped;
  logic                      cfg_wr_en;
  logic [MARGIN_W-1:0]       cfg_wr_data;

  voxel_histogram_board board;
  int                   results_seen = 0;
  int                   cycle_count  = 0;
  bit                   no_gaps      = 1'b0;

  point_cloud_voxel_histogram DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .last_point    (last_point),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .cell_z        (cell_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .cell_count    (cell_count),
    .binned_total  (binned_total),
    .peak_count    (peak_count),
    .points_dropped(points_dropped),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Both channels are sampled at the rising edge, where every input is stable.
  always @(posedge clk) begin
    voxel_req_t   b;
    voxel_reply_t r;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("point_cloud_voxel_histogram verification failed");
      $finish;
    end
    if (!rst) begin
      if (out_valid && out_ready) begin
        r = '{result_kind, cell_count, binned_total, peak_count, points_dropped};
        board.check_reply(r);
        results_seen++;
      end
      if (in_valid && in_ready) begin
        b = '{command, point_x, point_y, point_z, last_point, cell_x, cell_y, cell_z};
        board.note_beat(b);
      end
    end
  end

  // Output side: random ready pattern, plus one long hold-off while the
  // sender keeps offering beats so the block backs up into its input.
  initial begin : receiver
    int pick;
    int len;
    bit level;
    bit hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!hold_done && results_seen >= 30 && in_valid) begin
        hold_done = 1'b1;
        level     = 1'b0;
        len       = 5000;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          level = 1'b1;
          len   = $urandom_range(100, 300);
        end else if (pick < 65) begin
          level = 1'b1;
          len   = $urandom_range(1, 8);
        end else if (pick < 93) begin
          level = 1'b0;
          len   = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          len   = $urandom_range(20, 60);
        end
      end
      @(negedge clk);
      out_ready <= level;
      repeat (len - 1) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int pick;
    if (no_gaps) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Valid is only dropped when a gap is taken, so it stays high across
  // back-to-back beats.
  task automatic send_beat(input voxel_req_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    command    <= b.command;
    point_x    <= b.px;
    point_y    <= b.py;
    point_z    <= b.pz;
    last_point <= b.last;
    cell_x     <= b.cx;
    cell_y     <= b.cy;
    cell_z     <= b.cz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_point(input int x, input int y, input int z, input bit last);
    voxel_req_t b;
    b.command = CMD_LOAD;
    b.px      = COORD_W'(x);
    b.py      = COORD_W'(y);
    b.pz      = COORD_W'(z);
    b.last    = last;
    b.cx      = CELL_IDX_W'($urandom);
    b.cy      = CELL_IDX_W'($urandom);
    b.cz      = CELL_IDX_W'($urandom);
    send_beat(b);
  endtask

  // Point fields and last_point carry noise on a read; the block ignores them.
  task automatic read_cell(input int cx, input int cy, input int cz);
    voxel_req_t b;
    b.command = CMD_READ;
    b.px      = COORD_W'($urandom);
    b.py      = COORD_W'($urandom);
    b.pz      = COORD_W'($urandom);
    b.last    = 1'($urandom);
    b.cx      = CELL_IDX_W'(cx);
    b.cy      = CELL_IDX_W'(cy);
    b.cz      = CELL_IDX_W'(cz);
    send_beat(b);
  endtask

  // Mostly reads cells that the last binning pass actually filled.
  task automatic read_some_cell();
    logic [11:0] idx;
    if (board.filled_cells.size() > 0 && $urandom_range(0, 3) != 0)
      idx = 12'(board.filled_cells[$urandom_range(0, board.filled_cells.size() - 1)]);
    else
      idx = 12'($urandom_range(0, NUM_CELLS - 1));
    read_cell(idx[11:8], idx[7:4], idx[3:0]);
  endtask

  // Margin writes happen only with nothing in flight.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_margin(input int m);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= MARGIN_W'(m);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    board.set_margin(m);
  endtask

  function automatic int pick_spread();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return 0;
    if (pick < 55) return $urandom_range(1, 8);
    if (pick < 85) return $urandom_range(9, 400);
    return 65535;
  endfunction

  function automatic int make_coord(input int c, input int sp);
    int v;
    if (sp >= 65535) return int'($urandom_range(0, 65535)) - 32768;
    v = c + int'($urandom_range(0, 2 * sp)) - sp;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  function automatic int pick_margin();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return 0;
    if (pick < 35) return 1000;
    if (pick < 50) return int'(MARGIN_RESET);
    return $urandom_range(0, 1000);
  endfunction

  initial begin : stimulus
    int sent;
    int objects;
    int npts;
    int nreads;
    int center[3];
    int spread[3];
    int pt[3];
    rst         = 1'b1;
    in_valid    = 1'b0;
    command     = CMD_LOAD;
    point_x     = '0;
    point_y     = '0;
    point_z     = '0;
    last_point  = 1'b0;
    cell_x      = '0;
    cell_y      = '0;
    cell_z      = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    board       = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Zero margin: an empty histogram, a flat object that bins nothing, and
    // a box whose maximum sits exactly on the open top edge.
    write_margin(0);
    read_cell(0, 0, 0);
    read_cell(15, 15, 15);
    load_point(5, -7, 100, 1'b1);
    load_point(0, 0, 0, 1'b0);
    load_point(0, 0, 50, 1'b1);
    read_cell(8, 8, 0);
    settle();

    // Default margin: the flat point now lands in the last cell; equal sides
    // on all axes; then the full coordinate range.
    write_margin(int'(MARGIN_RESET));
    load_point(5, -7, 100, 1'b1);
    read_cell(15, 15, 15);
    load_point(0, 0, 0, 1'b0);
    load_point(100, 100, 100, 1'b1);
    read_cell(0, 0, 0);
    read_cell(15, 15, 15);
    load_point(-32768, -32768, -32768, 1'b0);
    load_point(32767, 32767, 32767, 1'b0);
    load_point(0, -1, 1, 1'b1);
    read_cell(0, 0, 0);
    read_cell(7, 8, 8);
    settle();

    write_margin(1000);
    load_point(-32768, 32767, 0, 1'b0);
    load_point(32767, -32768, -5, 1'b0);
    load_point(100, 200, 300, 1'b1);
    read_cell(8, 7, 7);
    settle();

    sent    = 0;
    objects = 0;
    while (sent < RANDOM_ITEMS) begin
      if (objects % 8 == 7) begin
        settle();
        write_margin(pick_margin());
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      npts    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int a = 0; a < 3; a++) begin
        center[a] = int'($urandom_range(0, 65535)) - 32768;
        spread[a] = pick_spread();
      end
      for (int k = 0; k < npts; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          read_some_cell();
          sent++;
        end
        for (int a = 0; a < 3; a++) begin
          if ($urandom_range(0, 19) == 0)
            pt[a] = make_coord(0, 65535);
          else
            pt[a] = make_coord(center[a], spread[a]);
        end
        load_point(pt[0], pt[1], pt[2], k == npts - 1);
        sent++;
      end
      nreads = $urandom_range(0, 4);
      for (int k = 0; k < nreads; k++) begin
        read_some_cell();
        sent++;
      end
      objects++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("point_cloud_voxel_histogram verification clean");
    else
      $display("point_cloud_voxel_histogram verification failed");
    $finish;
  end

endmodule
